// ===== design/binary_min_heap_queue_core_macros.svh =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core_macros.svh
// Assertion helpers for the heap queue core; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BMHQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define BMHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMHQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define BMHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== design/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// Field widths, codes and item types of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int KEY_BITS  = 32;
  localparam int TAG_BITS  = 16;
  localparam int OCC_BITS  = 11;
  localparam int STAT_BITS = 2;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // Status codes
  localparam logic [STAT_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd2;

  // Input item
  typedef struct packed {
    logic                func;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } req_t;

  // Result item
  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [KEY_BITS-1:0]  out_key;
    logic [TAG_BITS-1:0]  out_tag;
    logic [OCC_BITS-1:0]  occupancy;
  } rsp_t;

  // One heap slot
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

endpackage

// ===== design/bmhq_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/binary_min_heap_queue_core.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue_core
// Min-heap priority queue of key/tag pairs held in one level-order RAM.
// Insert: per level climbed, read the parent, then move it down; stops at the root or a compare.
// Remove: read the root and the last entry, then per level fetch the children, move the smaller up.
// Remove on empty / insert on full: result in the cycle after the accept.
// One item at a time: a new item is accepted only while idle (busy_o low).
// Async active-low reset empties the queue; result strobe cannot be stalled.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_core_macros.svh"

module binary_min_heap_queue_core #(
  parameter int CAPACITY = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  bmhq_pkg::req_t  req_i,
  output logic            valid_o,
  output bmhq_pkg::rsp_t  rsp_o
);

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int IW  = AW + 2;
  localparam int OCC = bmhq_pkg::OCC_BITS;
  localparam int EW  = $bits(bmhq_pkg::entry_t);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_CHK  = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_RM_ROOT = 3'd3;
  localparam logic [2:0] S_RM_LAST = 3'd4;
  localparam logic [2:0] S_DN_CHK  = 3'd5;
  localparam logic [2:0] S_DN_L    = 3'd6;
  localparam logic [2:0] S_DN_R    = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW-1:0]    par_q, par_d;
  bmhq_pkg::entry_t item_q, item_d;
  bmhq_pkg::entry_t lch_q, lch_d;
  bmhq_pkg::rsp_t   rsp_q, rsp_d;
  logic             valid_q, valid_d;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  bmhq_pkg::entry_t mem_wdata, rd;
  logic [EW-1:0]    mem_rdata;

  logic [IW-1:0]    l_w, r_w, cnt_w;
  logic [AW:0]      pm1_w;
  logic [CW-1:0]    cnt_m1;
  logic [CW+OCC-1:0] cnt_ext;
  logic             accept;

  // Heap storage
  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (EW'(mem_wdata)),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd = bmhq_pkg::entry_t'(mem_rdata);

  // Index arithmetic: children, parent, last slot
  assign l_w     = {1'b0, pos_q, 1'b1};
  assign r_w     = l_w + 1'b1;
  assign cnt_w   = {{(IW-CW){1'b0}}, cnt_q};
  assign pm1_w   = {1'b0, pos_q} - 1'b1;
  assign cnt_m1  = cnt_q - 1'b1;
  assign cnt_ext = {{OCC{1'b0}}, cnt_q};
  assign accept  = start_i && (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    par_d     = par_q;
    item_d    = item_q;
    lch_d     = lch_q;
    rsp_d     = rsp_q;
    valid_d   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = item_q;
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          rsp_d.out_key   = '0;
          rsp_d.out_tag   = '0;
          rsp_d.status    = bmhq_pkg::ST_DONE;
          rsp_d.occupancy = cnt_ext[OCC-1:0];
          if (req_i.func == bmhq_pkg::FUNC_INSERT) begin
            if (cnt_q == CW'(CAPACITY)) begin
              rsp_d.status = bmhq_pkg::ST_FULL;
              valid_d      = 1'b1;
            end else begin
              item_d.key = req_i.key;
              item_d.tag = req_i.tag;
              pos_d      = cnt_q[AW-1:0];
              cnt_d      = cnt_q + 1'b1;
              state_d    = S_UP_CHK;
            end
          end else begin
            if (cnt_q == '0) begin
              rsp_d.status = bmhq_pkg::ST_EMPTY;
              valid_d      = 1'b1;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = S_RM_ROOT;
            end
          end
        end
      end

      // Sift up: fetch the parent or land at the root
      S_UP_CHK: begin
        if (pos_q == '0) begin
          mem_we          = 1'b1;
          rsp_d.occupancy = cnt_ext[OCC-1:0];
          valid_d         = 1'b1;
          state_d         = S_IDLE;
        end else begin
          par_d     = pm1_w[AW:1];
          mem_re    = 1'b1;
          mem_raddr = pm1_w[AW:1];
          state_d   = S_UP_CMP;
        end
      end

      // Parent strictly greater: move it down into the hole; else place the item and finish
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (rd.key > item_q.key) begin
          mem_wdata = rd;
          pos_d     = par_q;
          state_d   = S_UP_CHK;
        end else begin
          rsp_d.occupancy = cnt_ext[OCC-1:0];
          valid_d         = 1'b1;
          state_d         = S_IDLE;
        end
      end

      // Root captured as result; fetch the last entry
      S_RM_ROOT: begin
        rsp_d.out_key = rd.key;
        rsp_d.out_tag = rd.tag;
        mem_re        = 1'b1;
        mem_raddr     = cnt_m1[AW-1:0];
        cnt_d         = cnt_m1;
        state_d       = S_RM_LAST;
      end

      S_RM_LAST: begin
        item_d  = rd;
        pos_d   = '0;
        state_d = S_DN_CHK;
      end

      // Sift down: fetch the left child or settle here
      S_DN_CHK: begin
        if (l_w >= cnt_w) begin
          mem_we          = 1'b1;
          rsp_d.occupancy = cnt_ext[OCC-1:0];
          valid_d         = 1'b1;
          state_d         = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = l_w[AW-1:0];
          state_d   = S_DN_L;
        end
      end

      // Left child in hand; fetch the right one if it exists
      S_DN_L: begin
        lch_d = rd;
        if (r_w < cnt_w) begin
          mem_re    = 1'b1;
          mem_raddr = r_w[AW-1:0];
          state_d   = S_DN_R;
        end else if (item_q.key > rd.key) begin
          mem_we    = 1'b1;
          mem_wdata = rd;
          pos_d     = l_w[AW-1:0];
          state_d   = S_DN_CHK;
        end else begin
          mem_we          = 1'b1;
          rsp_d.occupancy = cnt_ext[OCC-1:0];
          valid_d         = 1'b1;
          state_d         = S_IDLE;
        end
      end

      // Both children known; equal children favor the right one
      S_DN_R: begin
        mem_we = 1'b1;
        if (!(item_q.key > lch_q.key) && !(item_q.key > rd.key)) begin
          rsp_d.occupancy = cnt_ext[OCC-1:0];
          valid_d         = 1'b1;
          state_d         = S_IDLE;
        end else if (lch_q.key < rd.key) begin
          mem_wdata = lch_q;
          pos_d     = l_w[AW-1:0];
          state_d   = S_DN_CHK;
        end else begin
          mem_wdata = rd;
          pos_d     = r_w[AW-1:0];
          state_d   = S_DN_CHK;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    par_q  <= par_d;
    item_q <= item_d;
    lch_q  <= lch_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  // Checks
  `BMHQ_ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CW'(CAPACITY),
                    "entry count above capacity")
  `BMHQ_ASSERT_IMPL(a_wr_in_heap, clk_i, rst_ni, mem_we && (cnt_q != '0),
                    ({{(CW-AW){1'b0}}, mem_waddr} < cnt_q), "write beyond the last entry")
  `BMHQ_ASSERT_IMPL(a_no_rw_clash, clk_i, rst_ni, mem_we && mem_re,
                    mem_waddr != mem_raddr, "read and write hit the same slot")
  `BMHQ_ASSERT_IMPL(a_full_status, clk_i, rst_ni,
                    valid_q && (rsp_q.status == bmhq_pkg::ST_FULL),
                    cnt_q == CW'(CAPACITY), "full status with free slots")
  `BMHQ_ASSERT_NEXT(a_result_once, clk_i, rst_ni, valid_q && !start_i, !valid_q,
                    "result strobe without a new item")

endmodule
